[rtl/irpdt_pkg.sv]
// Shared types, constants and helpers for the IR pulse-distance transmitter.
`timescale 1ns / 1ps
package irpdt_pkg;

  // Field widths of the channels.
  localparam int OP_W     = 2;
  localparam int CODE_W   = 32;
  localparam int DIGIT_W  = 8;
  localparam int TICKS_W  = 16;
  localparam int CFG_IDX_W = 3;

  // Default and largest supported number of data bits in a frame.
  localparam int CODE_BITS_DEF = 32;
  localparam int MAX_CODE_BITS = 64;

  // Operation codes of an input word.
  localparam logic [OP_W-1:0] OP_RAW    = 2'd0;
  localparam logic [OP_W-1:0] OP_DIGITS = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LEAD_MARK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEAD_SPACE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE  = 3'd4;

  // Register reset values (NEC timing in microseconds).
  localparam logic [TICKS_W-1:0] LEAD_MARK_RST  = 16'd9000;
  localparam logic [TICKS_W-1:0] LEAD_SPACE_RST = 16'd4500;
  localparam logic [TICKS_W-1:0] BIT_MARK_RST   = 16'd562;
  localparam logic [TICKS_W-1:0] ZERO_SPACE_RST = 16'd562;
  localparam logic [TICKS_W-1:0] ONE_SPACE_RST  = 16'd1687;

  // Frame phase, one-hot.
  typedef enum logic [5:0] {
    PH_IDLE       = 6'b000001,
    PH_LEAD_MARK  = 6'b000010,
    PH_LEAD_SPACE = 6'b000100,
    PH_BIT_MARK   = 6'b001000,
    PH_BIT_SPACE  = 6'b010000,
    PH_STOP_MARK  = 6'b100000
  } phase_t;

  // Phase lengths as currently programmed.
  typedef struct packed {
    logic [TICKS_W-1:0] lead_mark;
    logic [TICKS_W-1:0] lead_space;
    logic [TICKS_W-1:0] bit_mark;
    logic [TICKS_W-1:0] zero_space;
    logic [TICKS_W-1:0] one_space;
  } cfg_t;

  // One input word.
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [CODE_W-1:0]  raw_code;
    logic [DIGIT_W-1:0] first_digit;
    logic [DIGIT_W-1:0] second_digit;
    logic [DIGIT_W-1:0] third_digit;
  } in_item_t;

  // One result word.
  typedef struct packed {
    logic carrier_on;
    logic busy_res;
    logic frame_done;
    logic start_rejected;
  } res_t;

  // A programmed length of zero counts as one tick.
  function automatic logic [TICKS_W-1:0] len_of(input logic [TICKS_W-1:0] v);
    len_of = (v == '0) ? TICKS_W'(1) : v;
  endfunction

endpackage

[rtl/irpdt_if.sv]
// Channel interfaces: input word stream, result word stream and register writes.
`timescale 1ns / 1ps
interface irpdt_in_if;
  import irpdt_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [CODE_W-1:0]  raw_code;
  logic [DIGIT_W-1:0] first_digit;
  logic [DIGIT_W-1:0] second_digit;
  logic [DIGIT_W-1:0] third_digit;
  modport source (output valid, op, raw_code, first_digit, second_digit, third_digit,
                  input ready);
  modport sink   (input valid, op, raw_code, first_digit, second_digit, third_digit,
                  output ready);
endinterface

interface irpdt_out_if;
  logic valid;
  logic ready;
  logic carrier_on;
  logic busy_res;
  logic frame_done;
  logic start_rejected;
  modport source (output valid, carrier_on, busy_res, frame_done, start_rejected,
                  input ready);
  modport sink   (input valid, carrier_on, busy_res, frame_done, start_rejected,
                  output ready);
endinterface

interface irpdt_cfg_if;
  import irpdt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TICKS_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/ir_pulse_distance_transmitter.sv]
// Top level of the NEC-style IR pulse-distance transmitter.
// The result word of an accepted input word is registered and offered in the following cycle.
// Throughput: one word per cycle; the sequencer step is a counter compare and phase update.
// The result register frees in the same cycle it is taken, so input stalls only on output stall.
// Reset (synchronous, rst_n low): idle phase, cleared timer and code, registers at NEC defaults.
`timescale 1ns / 1ps
module ir_pulse_distance_transmitter #(
  parameter int CODE_BITS = irpdt_pkg::CODE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  irpdt_in_if.sink     in_if,
  irpdt_out_if.source  out_if,
  irpdt_cfg_if.sink    cfg_if
);
  import irpdt_pkg::*;

  cfg_t     cfg;
  in_item_t item;
  res_t     res;
  res_t     res_r;
  logic     out_valid_r;
  logic     in_accept;

  // Register writes are always taken.
  assign cfg_if.ready = 1'b1;

  irpdt_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_if.valid),
    .wr_index (cfg_if.index),
    .wr_data  (cfg_if.data),
    .cfg      (cfg)
  );

  // Input word and handshake.
  assign item.op           = in_if.op;
  assign item.raw_code     = in_if.raw_code;
  assign item.first_digit  = in_if.first_digit;
  assign item.second_digit = in_if.second_digit;
  assign item.third_digit  = in_if.third_digit;
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_accept   = in_if.valid && in_if.ready;

  irpdt_seq #(.CODE_BITS(CODE_BITS)) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .item   (item),
    .cfg    (cfg),
    .res    (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.carrier_on     = res_r.carrier_on;
  assign out_if.busy_res       = res_r.busy_res;
  assign out_if.frame_done     = res_r.frame_done;
  assign out_if.start_rejected = res_r.start_rejected;

endmodule

[rtl/irpdt_cfg_regs.sv]
// Register file holding the five phase lengths.
`timescale 1ns / 1ps
module irpdt_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [irpdt_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [irpdt_pkg::TICKS_W-1:0]   wr_data,
  output irpdt_pkg::cfg_t                cfg
);
  import irpdt_pkg::*;

  cfg_t cfg_r;

  // Write the addressed register; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lead_mark  <= LEAD_MARK_RST;
      cfg_r.lead_space <= LEAD_SPACE_RST;
      cfg_r.bit_mark   <= BIT_MARK_RST;
      cfg_r.zero_space <= ZERO_SPACE_RST;
      cfg_r.one_space  <= ONE_SPACE_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_LEAD_MARK:  cfg_r.lead_mark  <= wr_data;
        REG_LEAD_SPACE: cfg_r.lead_space <= wr_data;
        REG_BIT_MARK:   cfg_r.bit_mark   <= wr_data;
        REG_ZERO_SPACE: cfg_r.zero_space <= wr_data;
        REG_ONE_SPACE:  cfg_r.one_space  <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/irpdt_seq.sv]
// Frame sequencer: phase, phase timer, data shift register and bit count.
`timescale 1ns / 1ps
module irpdt_seq #(
  parameter int CODE_BITS = irpdt_pkg::CODE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  irpdt_pkg::in_item_t item,
  input  irpdt_pkg::cfg_t     cfg,
  output irpdt_pkg::res_t     res
);
  import irpdt_pkg::*;

  localparam int BITS_W = $clog2(CODE_BITS + 1);

  phase_t               phase_r, phase_nxt;
  logic [TICKS_W-1:0]   timer_r, timer_nxt;
  logic [CODE_BITS-1:0] shift_r, shift_nxt;
  logic [BITS_W-1:0]    bits_r, bits_nxt;

  logic [TICKS_W:0]         timer_inc;
  logic [TICKS_W-1:0]       cur_len;
  logic [CODE_W-1:0]        load_code;
  logic [MAX_CODE_BITS-1:0] code_wide;
  logic [BITS_W-1:0]        bits_inc;
  logic                     is_start;
  logic                     done;
  logic                     rejected;

  // Code to load: raw, or three digits followed by their XOR checksum.
  always_comb begin
    if (item.op == OP_RAW) begin
      load_code = item.raw_code;
    end else begin
      load_code = {item.first_digit, item.second_digit, item.third_digit,
                   item.first_digit ^ item.second_digit ^ item.third_digit};
    end
    code_wide = {{(MAX_CODE_BITS-CODE_W){1'b0}}, load_code};
  end

  // Length of the phase in progress.
  always_comb begin
    case (phase_r)
      PH_LEAD_MARK:  cur_len = len_of(cfg.lead_mark);
      PH_LEAD_SPACE: cur_len = len_of(cfg.lead_space);
      PH_BIT_MARK:   cur_len = len_of(cfg.bit_mark);
      PH_BIT_SPACE:  cur_len = shift_r[0] ? len_of(cfg.one_space) : len_of(cfg.zero_space);
      PH_STOP_MARK:  cur_len = len_of(cfg.bit_mark);
      default:       cur_len = TICKS_W'(1);
    endcase
  end

  assign timer_inc = {1'b0, timer_r} + 1'b1;
  assign bits_inc  = bits_r + 1'b1;
  assign is_start  = item.op inside {OP_RAW, OP_DIGITS};

  // Next state for an accepted word.
  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    shift_nxt = shift_r;
    bits_nxt  = bits_r;
    done      = 1'b0;
    rejected  = 1'b0;
    if (is_start) begin
      if (phase_r != PH_IDLE) begin
        rejected = 1'b1;
      end else begin
        shift_nxt = code_wide[CODE_BITS-1:0];
        bits_nxt  = '0;
        timer_nxt = '0;
        phase_nxt = PH_LEAD_MARK;
      end
    end else if (item.op == OP_TICK && phase_r != PH_IDLE) begin
      if (timer_inc >= {1'b0, cur_len}) begin
        timer_nxt = '0;
        case (phase_r)
          PH_LEAD_MARK:  phase_nxt = PH_LEAD_SPACE;
          PH_LEAD_SPACE: phase_nxt = PH_BIT_MARK;
          PH_BIT_MARK:   phase_nxt = PH_BIT_SPACE;
          PH_BIT_SPACE: begin
            shift_nxt = shift_r >> 1;
            bits_nxt  = bits_inc;
            phase_nxt = (bits_inc >= BITS_W'(CODE_BITS)) ? PH_STOP_MARK : PH_BIT_MARK;
          end
          default: begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
        endcase
      end else begin
        timer_nxt = timer_inc[TICKS_W-1:0];
      end
    end
  end

  // State registers advance only on an accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      timer_r <= '0;
      shift_r <= '0;
      bits_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      shift_r <= shift_nxt;
      bits_r  <= bits_nxt;
    end
  end

  // Result word as seen after this step.
  always_comb begin
    res.carrier_on     = (phase_nxt == PH_LEAD_MARK) || (phase_nxt == PH_BIT_MARK) ||
                         (phase_nxt == PH_STOP_MARK);
    res.busy_res       = (phase_nxt != PH_IDLE);
    res.frame_done     = done;
    res.start_rejected = rejected;
  end

endmodule

[rtl/irpdt_checker.sv]
// Port-level checks on the result stream of the transmitter, bound to the top level.
`timescale 1ns / 1ps
module irpdt_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic carrier_on,
  input logic busy_res,
  input logic frame_done,
  input logic start_rejected
);

  // A stalled result word holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({carrier_on, busy_res, frame_done, start_rejected}))
    else $error("result word changed while stalled");

  // The carrier is only gated on inside a frame.
  a_carrier_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && carrier_on |-> busy_res)
    else $error("carrier on outside a frame");

  // The end of a frame leaves the block idle with the carrier off.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_done |-> !busy_res && !carrier_on)
    else $error("frame done while still busy");

  // A start is only rejected while a frame is running.
  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && start_rejected |-> busy_res && !frame_done)
    else $error("start rejected while idle");

endmodule

bind ir_pulse_distance_transmitter irpdt_checker u_irpdt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .carrier_on     (out_if.carrier_on),
  .busy_res       (out_if.busy_res),
  .frame_done     (out_if.frame_done),
  .start_rejected (out_if.start_rejected)
);

[sim/irpdt_checker.sv]
// Checker that predicts every result word of the IR transmitter and compares it with the block.
`timescale 1ns / 1ps
module irpdt_tb_checker #(
  parameter int CODE_BITS = irpdt_pkg::CODE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  irpdt_in_if  in_w,
  irpdt_out_if out_w,
  irpdt_cfg_if cfg_w,
  output int   mismatches,
  output int   outstanding,
  output int   words_checked,
  output int   frames_sent,
  output int   starts_refused
);
  import irpdt_pkg::*;

  // Shadow of the programmed timing and of the frame sequencer.
  cfg_t         lens;
  phase_t       ph;
  int unsigned  tmr;
  logic [63:0]  code;
  int unsigned  nsent;
  res_t         pending_words[$];

  // A programmed length of zero lasts one tick.
  function automatic int unsigned ticks_of(input logic [TICKS_W-1:0] v);
    return (v == '0) ? 1 : int'(v);
  endfunction

  function automatic int unsigned phase_ticks();
    case (ph)
      PH_LEAD_MARK:  return ticks_of(lens.lead_mark);
      PH_LEAD_SPACE: return ticks_of(lens.lead_space);
      PH_BIT_MARK:   return ticks_of(lens.bit_mark);
      PH_BIT_SPACE:  return code[0] ? ticks_of(lens.one_space) : ticks_of(lens.zero_space);
      PH_STOP_MARK:  return ticks_of(lens.bit_mark);
      default:       return 1;
    endcase
  endfunction

  // Apply one input word to the shadow sequencer and return the word the block should send.
  function automatic res_t frame_step(input in_item_t w);
    res_t        r;
    int unsigned nxt;
    r = '0;
    case (w.op)
      OP_RAW, OP_DIGITS: begin
        if (ph != PH_IDLE) begin
          r.start_rejected = 1'b1;
        end else begin
          if (w.op == OP_RAW) begin
            code = {32'b0, w.raw_code};
          end else begin
            code = {32'b0, w.first_digit, w.second_digit, w.third_digit,
                    w.first_digit ^ w.second_digit ^ w.third_digit};
          end
          nsent = 0;
          tmr   = 0;
          ph    = PH_LEAD_MARK;
        end
      end
      OP_TICK: begin
        if (ph != PH_IDLE) begin
          nxt = tmr + 1;
          if (nxt >= phase_ticks()) begin
            tmr = 0;
            case (ph)
              PH_LEAD_MARK:  ph = PH_LEAD_SPACE;
              PH_LEAD_SPACE: ph = PH_BIT_MARK;
              PH_BIT_MARK:   ph = PH_BIT_SPACE;
              PH_BIT_SPACE: begin
                code  = code >> 1;
                nsent = nsent + 1;
                ph    = (nsent >= CODE_BITS) ? PH_STOP_MARK : PH_BIT_MARK;
              end
              default: begin
                ph = PH_IDLE;
                r.frame_done = 1'b1;
              end
            endcase
          end else begin
            tmr = nxt;
          end
        end
      end
      default: ;
    endcase
    r.carrier_on = (ph == PH_LEAD_MARK) || (ph == PH_BIT_MARK) || (ph == PH_STOP_MARK);
    r.busy_res   = (ph != PH_IDLE);
    return r;
  endfunction

  // All three channels are sampled at the clock edge; values seen here are the pre-edge ones.
  always @(posedge clk) begin
    in_item_t word;
    res_t     got;
    res_t     want;
    if (!rst_n) begin
      lens.lead_mark  = LEAD_MARK_RST;
      lens.lead_space = LEAD_SPACE_RST;
      lens.bit_mark   = BIT_MARK_RST;
      lens.zero_space = ZERO_SPACE_RST;
      lens.one_space  = ONE_SPACE_RST;
      ph              = PH_IDLE;
      tmr             = 0;
      code            = '0;
      nsent           = 0;
      pending_words.delete();
      mismatches      = 0;
      words_checked   = 0;
      frames_sent     = 0;
      starts_refused  = 0;
    end else begin
      // Result word taken by the receiver: compare with the oldest prediction.
      if (out_w.valid && out_w.ready) begin
        got.carrier_on     = out_w.carrier_on;
        got.busy_res       = out_w.busy_res;
        got.frame_done     = out_w.frame_done;
        got.start_rejected = out_w.start_rejected;
        if (pending_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result word with nothing predicted:", $realtime,
                     " carrier %0b busy %0b done %0b rej %0b",
                     got.carrier_on, got.busy_res, got.frame_done, got.start_rejected);
          end
        end else begin
          want = pending_words.pop_front();
          words_checked++;
          if (want.frame_done) frames_sent++;
          if (want.start_rejected) starts_refused++;
          if (got.carrier_on !== want.carrier_on || got.busy_res !== want.busy_res ||
              got.frame_done !== want.frame_done ||
              got.start_rejected !== want.start_rejected) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result word %0d differs:", $realtime, words_checked,
                       " carrier %0b/%0b busy %0b/%0b", want.carrier_on, got.carrier_on,
                       want.busy_res, got.busy_res,
                       " done %0b/%0b rej %0b/%0b (want/got)",
                       want.frame_done, got.frame_done,
                       want.start_rejected, got.start_rejected);
            end
          end
        end
      end

      // Register writes take effect at once, also in the middle of a frame.
      if (cfg_w.valid && cfg_w.ready) begin
        case (cfg_w.index)
          REG_LEAD_MARK:  lens.lead_mark  = cfg_w.data;
          REG_LEAD_SPACE: lens.lead_space = cfg_w.data;
          REG_BIT_MARK:   lens.bit_mark   = cfg_w.data;
          REG_ZERO_SPACE: lens.zero_space = cfg_w.data;
          REG_ONE_SPACE:  lens.one_space  = cfg_w.data;
          default: ;
        endcase
      end

      // Input word accepted: every word produces exactly one result word.
      if (in_w.valid && in_w.ready) begin
        word.op           = in_w.op;
        word.raw_code     = in_w.raw_code;
        word.first_digit  = in_w.first_digit;
        word.second_digit = in_w.second_digit;
        word.third_digit  = in_w.third_digit;
        pending_words.push_back(frame_step(word));
      end
    end
    outstanding <= pending_words.size();
  end

endmodule

[sim/ir_pulse_distance_transmitter_tb.sv]
// Testbench top: drives frames, ticks and timing writes into the IR transmitter and gives the verdict.
`timescale 1ns / 1ps
module ir_pulse_distance_transmitter_tb;
  import irpdt_pkg::*;

  localparam int CODE_BITS    = CODE_BITS_DEF;
  localparam int LIMIT        = 500000;
  localparam int PHASE_WORDS  = 92;
  localparam int HOLD_CYCLES  = 400;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  logic clk;
  logic rst_n;
  int   tx_idle_pct;
  int   rx_idle_pct;
  logic hold_req;
  int   settings_used;
  int   mismatches;
  int   outstanding;
  int   words_checked;
  int   frames_sent;
  int   starts_refused;

  irpdt_in_if  in_ch ();
  irpdt_out_if out_ch ();
  irpdt_cfg_if cfg_ch ();

  ir_pulse_distance_transmitter #(
    .CODE_BITS(CODE_BITS)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  irpdt_tb_checker #(
    .CODE_BITS(CODE_BITS)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_w           (in_ch),
    .out_w          (out_ch),
    .cfg_w          (cfg_ch),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .words_checked  (words_checked),
    .frames_sent    (frames_sent),
    .starts_refused (starts_refused)
  );

  // 100 MHz clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the whole run.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("ir_pulse_distance_transmitter_tb: FAIL");
    $finish;
  end

  // Result receiver: random stalls, plus one long hold-off on request to back up the input.
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offer one input word, with random idle cycles in front, and wait until it is taken.
  task automatic send_word(input in_item_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= w.op;
    in_ch.raw_code     <= w.raw_code;
    in_ch.first_digit  <= w.first_digit;
    in_ch.second_digit <= w.second_digit;
    in_ch.third_digit  <= w.third_digit;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Word of the given operation with random content in every other field.
  function automatic in_item_t any_word(input logic [OP_W-1:0] op);
    in_item_t w;
    w.op           = op;
    w.raw_code     = $urandom;
    w.first_digit  = 8'($urandom);
    w.second_digit = 8'($urandom);
    w.third_digit  = 8'($urandom);
    return w;
  endfunction

  // Mostly ticks, so that frames run through; starts and no-ops sprinkled in.
  function automatic in_item_t mixed_word();
    int roll;
    roll = $urandom_range(99);
    if (roll < 90) return any_word(OP_TICK);
    if (roll < 94) return any_word(OP_RAW);
    if (roll < 98) return any_word(OP_DIGITS);
    return any_word(OP_NONE);
  endfunction

  task automatic send_ticks(input int n);
    repeat (n) send_word(any_word(OP_TICK));
  endtask

  // Stop offering words and wait until every predicted result word has come back.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICKS_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic load_timing(input cfg_t c);
    write_reg(REG_LEAD_MARK, c.lead_mark);
    write_reg(REG_LEAD_SPACE, c.lead_space);
    write_reg(REG_BIT_MARK, c.bit_mark);
    write_reg(REG_ZERO_SPACE, c.zero_space);
    write_reg(REG_ONE_SPACE, c.one_space);
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  function automatic cfg_t timing_all(input logic [TICKS_W-1:0] v);
    cfg_t c;
    c.lead_mark  = v;
    c.lead_space = v;
    c.bit_mark   = v;
    c.zero_space = v;
    c.one_space  = v;
    return c;
  endfunction

  function automatic cfg_t timing_random(input int hi);
    cfg_t c;
    c.lead_mark  = TICKS_W'($urandom_range(hi));
    c.lead_space = TICKS_W'($urandom_range(hi));
    c.bit_mark   = TICKS_W'($urandom_range(hi));
    c.zero_space = TICKS_W'($urandom_range(hi));
    c.one_space  = TICKS_W'($urandom_range(hi));
    return c;
  endfunction

  // Stimulus and verdict.
  initial begin
    in_item_t w;
    cfg_t     t;
    tx_idle_pct   = 0;
    settings_used = 0;
    rx_idle_pct        <= 0;
    hold_req           <= 1'b0;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.op           <= OP_TICK;
    in_ch.raw_code     <= '0;
    in_ch.first_digit  <= '0;
    in_ch.second_digit <= '0;
    in_ch.third_digit  <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= REG_LEAD_MARK;
    cfg_ch.data        <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: tick and no-op while idle, start under reset timing, starts refused while busy.
    send_word(any_word(OP_TICK));
    send_word(any_word(OP_NONE));
    w = any_word(OP_RAW);
    w.raw_code = '1;
    send_word(w);
    w = any_word(OP_RAW);
    w.raw_code = '0;
    send_word(w);
    w = any_word(OP_DIGITS);
    w.first_digit  = 8'hff;
    w.second_digit = 8'h00;
    w.third_digit  = 8'ha5;
    send_word(w);
    send_word(any_word(OP_NONE));
    send_ticks(3);

    // Shorten the frame in flight and let it finish, then send an all-zero and an all-ones digit code.
    settle();
    load_timing(timing_all(16'd1));
    send_ticks(70);
    w = any_word(OP_DIGITS);
    w.first_digit  = 8'h00;
    w.second_digit = 8'h00;
    w.third_digit  = 8'h00;
    send_word(w);
    send_ticks(70);
    w = any_word(OP_DIGITS);
    w.first_digit  = 8'hff;
    w.second_digit = 8'hff;
    w.third_digit  = 8'hff;
    send_word(w);
    send_ticks(70);

    // Random part in three idling modes, three timing settings each.
    for (int seg = 0; seg < 3; seg++) begin
      case (seg)
        0: begin
          tx_idle_pct = 36;
          rx_idle_pct <= 65;
        end
        1: begin
          tx_idle_pct = 65;
          rx_idle_pct <= 36;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
        end
      endcase
      for (int k = 0; k < 3; k++) begin
        settle();
        case (k)
          0: t = timing_random(3);
          1: t = (seg == 0) ? timing_all(16'd0) : (seg == 1) ? timing_all(16'd1)
                                                             : timing_random(2);
          default: t = timing_random(8);
        endcase
        load_timing(t);
        for (int n = 0; n < PHASE_WORDS; n++) begin
          if (seg == 2 && k == 0 && n == 20) hold_req <= 1'b1;
          send_word(mixed_word());
        end
      end
    end

    // All lengths at their top value, then rewritten to zero in the middle of the frame.
    settle();
    load_timing(timing_all('1));
    send_word(any_word(OP_DIGITS));
    send_ticks(200);
    settle();
    load_timing(timing_all(16'd0));
    send_ticks(100);

    settle();
    repeat (4) @(posedge clk);
    $display("Checked %0d result words over %0d timing settings (zero and 65535 included).",
             words_checked, settings_used);
    $display("Frames completed: %0d, starts refused while busy: %0d, mismatches: %0d.",
             frames_sent, starts_refused, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("ir_pulse_distance_transmitter_tb: PASS");
    end else begin
      $display("ir_pulse_distance_transmitter_tb: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/irpdt_pkg.sv
rtl/irpdt_if.sv
rtl/irpdt_cfg_regs.sv
rtl/irpdt_seq.sv
rtl/ir_pulse_distance_transmitter.sv
rtl/irpdt_checker.sv
sim/irpdt_checker.sv
sim/ir_pulse_distance_transmitter_tb.sv
